// File: rtl/ecn_pkg.sv
// ----------------------------------------------------------------------------
// ecn_pkg: shared types and constants of the ECEF/NED rotation block.
// Holds the angle constants, the CORDIC arctangent table and angle types.
// ----------------------------------------------------------------------------
package ecn_pkg;

  // Angles in degrees, LSB 2^-22 degree, held in 33 signed bits.
  localparam logic signed [32:0] DEG_90  = 33'sd377487360;
  localparam logic signed [32:0] DEG_180 = 33'sd754974720;
  localparam logic signed [32:0] DEG_360 = 33'sd1509949440;

  // Radians per degree in Q40, split as KH * 2^18 + KL.
  localparam logic signed [17:0] RAD_KH = 18'sd73204;
  localparam logic signed [17:0] RAD_KL = 18'sd108693;

  // CORDIC start value (inverse gain, Q30).
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

  // Width of the CORDIC x and y datapath and of matrix entries.
  localparam int XW = 34;
  localparam int MW = 34;

  // An angle after folding: radians Q30 plus a cosine sign flag.
  typedef struct packed {
    logic               flip;
    logic signed [31:0] z;
  } ecn_ang_t;

  // An angle in degrees after wrapping and folding.
  typedef struct packed {
    logic               flip;
    logic signed [32:0] d;
  } ecn_fold_t;

  // Wrap an angle into [-180,180] degrees and fold it into [-90,90].
  function automatic ecn_fold_t fold_angle(input logic signed [32:0] d_in);
    logic signed [32:0] w;
    ecn_fold_t          f;
    w = d_in;
    if (w > DEG_180) begin
      w = w - DEG_360;
    end else if (w < -DEG_180) begin
      w = w + DEG_360;
    end
    f.flip = 1'b0;
    f.d    = w;
    if (w > DEG_90) begin
      f.d    = DEG_180 - w;
      f.flip = 1'b1;
    end else if (w < -DEG_90) begin
      f.d    = -DEG_180 - w;
      f.flip = 1'b1;
    end
    return f;
  endfunction

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [33:0] atan_entry(input int i);
    logic signed [33:0] a;
    unique case (i)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      default: a = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/ecef_ned_rotation_top.sv
// ----------------------------------------------------------------------------
// ecef_ned_rotation_top: ECEF <-> NED vector rotation.
// Top level: stream ports, front stage, queue and execution back end.
// ----------------------------------------------------------------------------
// The block takes one vector transaction per clock cycle while the output
// side keeps up, and returns one rotated vector for each, in order. An item
// passes CORDIC_STEPS + 9 register stages: three front stages (the first
// loaded at the accepting edge), one queue entry, one CORDIC stage per
// iteration, and five matrix and dot-product stages ending in the output
// register. Throughput is set by the fully pipelined CORDIC and multiplier
// stages, one item per cycle while the output is not stalled. The four-entry
// queue lets the input side keep accepting while the output is briefly
// stalled. No state is kept between items, and no configuration is needed.
module ecef_ned_rotation_top #(
  parameter int CORDIC_STEPS = 24,
  parameter int VEC_WIDTH    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // latitude[29:0], longitude[60:30], comp_x, comp_y, comp_z, zero pad
  input  logic [((61+3*VEC_WIDTH+7)/8)*8-1:0] in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // res_x, res_y, res_z, zero pad
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0]    out_tdata,
  // clipped
  output logic                  out_tuser
);

  localparam int VW  = VEC_WIDTH;
  localparam int ODW = ((3*VW+7)/8)*8;
  localparam int QDW = 1 + 2*$bits(ecn_pkg::ecn_ang_t) + 3*VW;

  logic                push, full, pop, empty;
  logic                f_cmd, b_cmd;
  ecn_pkg::ecn_ang_t   f_lat, f_lon, b_lat, b_lon;
  logic [3*VW-1:0]     f_vec, b_vec, res;

  ecn_front #(.VW(VW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .command(in_tuser),
    .latitude($signed(in_tdata[29:0])),
    .longitude($signed(in_tdata[60:30])),
    .comp_x($signed(in_tdata[61 +: VW])),
    .comp_y($signed(in_tdata[61+VW +: VW])),
    .comp_z($signed(in_tdata[61+2*VW +: VW])),
    .push(push), .full(full),
    .q_cmd(f_cmd), .q_lat(f_lat), .q_lon(f_lon), .q_vec(f_vec)
  );

  ecn_fifo #(.DW(QDW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata({f_cmd, f_lat, f_lon, f_vec}), .full(full),
    .pop(pop), .rdata({b_cmd, b_lat, b_lon, b_vec}), .empty(empty)
  );

  ecn_back #(.STEPS(CORDIC_STEPS), .VW(VW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .empty(empty), .pop(pop),
    .q_cmd(b_cmd), .q_lat(b_lat), .q_lon(b_lon), .q_vec(b_vec),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .res(res), .clipped(out_tuser)
  );

  assign out_tdata = ODW'(res);

endmodule

// File: rtl/ecn_front.sv
// ----------------------------------------------------------------------------
// ecn_front: input stage of the rotation block.
// Accepts transactions, wraps and folds both angles and converts them to
// radians in Q30, then hands the item to the queue.
// ----------------------------------------------------------------------------
module ecn_front #(
  parameter int VW = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic signed [29:0]     latitude,
  input  logic signed [30:0]     longitude,
  input  logic signed [VW-1:0]   comp_x,
  input  logic signed [VW-1:0]   comp_y,
  input  logic signed [VW-1:0]   comp_z,
  output logic                   push,
  input  logic                   full,
  output logic                   q_cmd,
  output ecn_pkg::ecn_ang_t      q_lat,
  output ecn_pkg::ecn_ang_t      q_lon,
  output logic [3*VW-1:0]        q_vec
);

  logic                  v1_r, v2_r, v3_r;
  logic                  en1, en2, en3;
  logic                  cmd1_r, cmd2_r, cmd3_r;
  logic [3*VW-1:0]       vec1_r, vec2_r, vec3_r;
  ecn_pkg::ecn_fold_t    lat1_r, lon1_r;
  logic                  latf2_r, lonf2_r;
  logic signed [50:0]    lat_ph_r, lat_pl_r, lon_ph_r, lon_pl_r;
  ecn_pkg::ecn_ang_t     lat3_r, lon3_r;
  logic signed [71:0]    lat_t, lon_t;

  // Stage flow control: a stage loads when it is empty or moves on.
  assign en3      = !v3_r || !full;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign push     = v3_r && !full;

  // Rounded conversion of the products to radians Q30.
  assign lat_t = (72'(lat_ph_r) <<< 18) + 72'(lat_pl_r) + (72'sd1 <<< 31);
  assign lon_t = (72'(lon_ph_r) <<< 18) + 72'(lon_pl_r) + (72'sd1 <<< 31);

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage 1: wrap and fold; stage 2: partial products; stage 3: rounding.
  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r <= command;
      vec1_r <= {comp_z, comp_y, comp_x};
      lat1_r <= ecn_pkg::fold_angle(33'(latitude));
      lon1_r <= ecn_pkg::fold_angle(33'(longitude));
    end
    if (en2) begin
      cmd2_r   <= cmd1_r;
      vec2_r   <= vec1_r;
      latf2_r  <= lat1_r.flip;
      lonf2_r  <= lon1_r.flip;
      lat_ph_r <= lat1_r.d * ecn_pkg::RAD_KH;
      lat_pl_r <= lat1_r.d * ecn_pkg::RAD_KL;
      lon_ph_r <= lon1_r.d * ecn_pkg::RAD_KH;
      lon_pl_r <= lon1_r.d * ecn_pkg::RAD_KL;
    end
    if (en3) begin
      cmd3_r      <= cmd2_r;
      vec3_r      <= vec2_r;
      lat3_r.flip <= latf2_r;
      lat3_r.z    <= lat_t[63:32];
      lon3_r.flip <= lonf2_r;
      lon3_r.z    <= lon_t[63:32];
    end
  end

  assign q_cmd = cmd3_r;
  assign q_lat = lat3_r;
  assign q_lon = lon3_r;
  assign q_vec = vec3_r;

endmodule

// File: rtl/ecn_fifo.sv
// ----------------------------------------------------------------------------
// ecn_fifo: short queue between the front and the back of the block.
// Four entries, registered count, read from the head.
// ----------------------------------------------------------------------------
module ecn_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

// File: rtl/ecn_cordic.sv
// ----------------------------------------------------------------------------
// ecn_cordic: pipelined rotation-mode CORDIC.
// One iteration per stage; yields cosine (sign-corrected) and sine in Q30.
// ----------------------------------------------------------------------------
module ecn_cordic #(
  parameter int STEPS = 24
) (
  input  logic                           clk,
  input  logic                           en,
  input  ecn_pkg::ecn_ang_t              ang,
  output logic signed [ecn_pkg::XW-1:0]  cos_o,
  output logic signed [ecn_pkg::XW-1:0]  sin_o
);

  localparam int XW = ecn_pkg::XW;

  logic signed [XW-1:0] x_r [STEPS];
  logic signed [XW-1:0] y_r [STEPS];
  logic signed [XW-1:0] z_r [STEPS];
  logic                 f_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [XW-1:0] xi, yi, zi;
    logic                 fi;
    if (k == 0) begin : g_first
      assign xi = ecn_pkg::CORDIC_INV_GAIN;
      assign yi = '0;
      assign zi = XW'(ang.z);
      assign fi = ang.flip;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign fi = f_r[k-1];
    end

    // One micro-rotation, direction from the residual sign.
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[k] <= fi;
        if (zi >= 0) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
          z_r[k] <= zi - ecn_pkg::atan_entry(k);
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
          z_r[k] <= zi + ecn_pkg::atan_entry(k);
        end
      end
    end
  end

  // A folded angle negates the cosine.
  assign cos_o = f_r[STEPS-1] ? -x_r[STEPS-1] : x_r[STEPS-1];
  assign sin_o = y_r[STEPS-1];

endmodule

// File: rtl/ecn_back.sv
// ----------------------------------------------------------------------------
// ecn_back: execution part of the rotation block.
// Runs both CORDICs, builds the rotation matrix, forms the three dot
// products and saturates them into the output register.
// ----------------------------------------------------------------------------
module ecn_back #(
  parameter int STEPS = 24,
  parameter int VW    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 empty,
  output logic                 pop,
  input  logic                 q_cmd,
  input  ecn_pkg::ecn_ang_t    q_lat,
  input  ecn_pkg::ecn_ang_t    q_lon,
  input  logic [3*VW-1:0]      q_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3*VW-1:0]      res,
  output logic                 clipped
);

  localparam int XW  = ecn_pkg::XW;
  localparam int MW  = ecn_pkg::MW;
  // Each vector component is split into a signed high part and an
  // unsigned low part of LB bits, so both partial products stay narrow.
  localparam int LB  = (VW > 24) ? 16 : VW / 2;
  localparam int HW  = VW - LB;
  localparam int PHW = MW + HW;
  localparam int PLW = MW + LB + 1;
  localparam int SW  = MW + VW + 3;
  localparam int RW  = SW - 30;
  localparam logic signed [RW-1:0] RMAX = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [RW-1:0] RMIN = ~RMAX;

  logic                 adv;
  logic                 cv_r [STEPS];
  logic                 cc_r [STEPS];
  logic [3*VW-1:0]      cvec_r [STEPS];
  logic signed [XW-1:0] cl, sl, co, so;

  logic                    v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic                    cmd1_r;
  logic [3*VW-1:0]         vec1_r, vec2_r;
  logic signed [XW-1:0]    cl1_r, sl1_r, co1_r, so1_r;
  logic signed [2*XW-1:0]  psc_r, pss_r, pcc_r, pcs_r;
  logic signed [MW-1:0]    fm [3][3];
  logic signed [MW-1:0]    row_r [3][3];
  logic signed [PHW-1:0]   ph_r [3][3];
  logic signed [PLW-1:0]   pl_r [3][3];
  logic signed [RW-1:0]    r_r [3];
  logic [3*VW-1:0]         res_r;
  logic                    clip_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !empty;

  ecn_cordic #(.STEPS(STEPS)) u_cordic_lat (
    .clk(clk), .en(adv), .ang(q_lat), .cos_o(cl), .sin_o(sl)
  );
  ecn_cordic #(.STEPS(STEPS)) u_cordic_lon (
    .clk(clk), .en(adv), .ang(q_lon), .cos_o(co), .sin_o(so)
  );

  // Command and vector ride alongside the CORDIC stages.
  for (genvar k = 0; k < STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k] <= 1'b0;
      end else if (adv) begin
        cv_r[k] <= (k == 0) ? pop : cv_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cc_r[k]   <= (k == 0) ? q_cmd : cc_r[(k == 0) ? 0 : k-1];
        cvec_r[k] <= (k == 0) ? q_vec : cvec_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Q30 rounding of the four angle products gives the forward matrix.
  function automatic logic signed [MW-1:0] qrnd(input logic signed [2*XW-1:0] p);
    logic signed [2*XW-1:0] t;
    t = (p + (2*XW)'(64'sd1 <<< 29)) >>> 30;
    return t[MW-1:0];
  endfunction

  always_comb begin
    fm[0][0] = -qrnd(psc_r);
    fm[0][1] = -qrnd(pss_r);
    fm[0][2] = cl1_r;
    fm[1][0] = -so1_r;
    fm[1][1] = co1_r;
    fm[1][2] = '0;
    fm[2][0] = -qrnd(pcc_r);
    fm[2][1] = -qrnd(pcs_r);
    fm[2][2] = -sl1_r;
  end

  // Valid bits of the matrix and output stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= cv_r[STEPS-1];
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Angle products, matrix rows, partial products, sums and saturation.
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= cc_r[STEPS-1];
      vec1_r <= cvec_r[STEPS-1];
      cl1_r  <= cl;
      sl1_r  <= sl;
      co1_r  <= co;
      so1_r  <= so;
      psc_r  <= sl * co;
      pss_r  <= sl * so;
      pcc_r  <= cl * co;
      pcs_r  <= cl * so;

      vec2_r <= vec1_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          row_r[i][j] <= cmd1_r ? fm[j][i] : fm[i][j];
        end
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph_r[i][j] <= row_r[i][j] * $signed(vec2_r[j*VW+LB +: HW]);
          pl_r[i][j] <= row_r[i][j] * $signed({1'b0, vec2_r[j*VW +: LB]});
        end
      end

      for (int i = 0; i < 3; i++) begin
        logic signed [SW-1:0] s;
        s = ((SW'(ph_r[i][0]) + SW'(ph_r[i][1]) + SW'(ph_r[i][2])) <<< LB)
            + SW'(pl_r[i][0]) + SW'(pl_r[i][1]) + SW'(pl_r[i][2])
            + (SW'(1) <<< 29);
        r_r[i] <= s[SW-1:30];
      end

      for (int i = 0; i < 3; i++) begin
        if (r_r[i] > RMAX) begin
          res_r[i*VW +: VW] <= RMAX[VW-1:0];
        end else if (r_r[i] < RMIN) begin
          res_r[i*VW +: VW] <= RMIN[VW-1:0];
        end else begin
          res_r[i*VW +: VW] <= r_r[i][VW-1:0];
        end
      end

      // Any component out of range raises the clip flag.
      clip_r <= (r_r[0] > RMAX) || (r_r[0] < RMIN) ||
                (r_r[1] > RMAX) || (r_r[1] < RMIN) ||
                (r_r[2] > RMAX) || (r_r[2] < RMIN);
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign clipped   = clip_r;

endmodule

// File: rtl/ecn_checker.sv
// ----------------------------------------------------------------------------
// ecn_checker: port-level checks of the rotation block.
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ecn_checker #(
  parameter int VEC_WIDTH = 32
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((3*VEC_WIDTH+7)/8)*8-1:0]     out_tdata,
  input logic                                 out_tuser
);

  localparam int VW = VEC_WIDTH;
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its data.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A clipped result has a component at a range limit.
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[0 +: VW] == VMAX || out_tdata[0 +: VW] == VMIN ||
      out_tdata[VW +: VW] == VMAX || out_tdata[VW +: VW] == VMIN ||
      out_tdata[2*VW +: VW] == VMAX || out_tdata[2*VW +: VW] == VMIN)
    else $error("clip flag without a saturated component");

  // The block is ready for input as soon as reset is released.
  a_ready: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> in_tready)
    else $error("input not ready after reset");

endmodule

bind ecef_ned_rotation_top ecn_checker #(.VEC_WIDTH(VEC_WIDTH)) u_ecn_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
